[sv/nmrb_pkg.sv]
`default_nettype none
package nmrb_pkg;

	// Bank geometry
	localparam int MAILBOXES  = 16;
	localparam int RING_BYTES = 64;

	// Indexes that open can search: bounded by the 4-bit opened_index
	localparam int OPEN_SPAN = (MAILBOXES < 16) ? MAILBOXES : 16;

	// Derived widths
	localparam int IDX_W  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
	localparam int SCAN_W = (OPEN_SPAN > 1) ? $clog2(OPEN_SPAN) : 1;
	localparam int POS_W  = $clog2(RING_BYTES);
	localparam int FREE_W = $clog2(RING_BYTES + 1);
	localparam int WORDS  = MAILBOXES * RING_BYTES;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	// Payload field widths
	localparam int OP_W     = 2;
	localparam int MBX_W    = 4;
	localparam int KEY_W    = 64;
	localparam int DATA_W   = 64;
	localparam int CNT_W    = 4;
	localparam int STATUS_W = 2;
	localparam int FREEB_W  = 7;
	localparam int MAX_BYTES = 8;

	typedef enum logic [OP_W-1:0] {
		OP_OPEN  = 2'd0,
		OP_CLOSE = 2'd1,
		OP_SEND  = 2'd2,
		OP_RECV  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_BLOCK  = 2'd1,
		STS_NOFREE = 2'd2,
		STS_RSVD   = 2'd3
	} status_t;

	// Ring pointer advance with wraparound
	function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p);
		logic [POS_W:0] s;
		s = {1'b0, p} + {{POS_W{1'b0}}, 1'b1};
		if (s == (POS_W+1)'(RING_BYTES))
			return '0;
		return s[POS_W-1:0];
	endfunction

endpackage
`default_nettype wire

[sv/nmrb_if.sv]
`default_nettype none
// Request channel
interface nmrb_req_if;
	logic                         valid;
	logic                         ready;
	logic [nmrb_pkg::OP_W-1:0]    op;
	logic [nmrb_pkg::MBX_W-1:0]   mailbox_index;
	logic [nmrb_pkg::KEY_W-1:0]   name_key;
	logic [nmrb_pkg::DATA_W-1:0]  msg_data;
	logic [nmrb_pkg::CNT_W-1:0]   byte_count;

	modport source (output valid, op, mailbox_index, name_key, msg_data, byte_count,
		input ready);
	modport sink (input valid, op, mailbox_index, name_key, msg_data, byte_count,
		output ready);
endinterface

// Response channel
interface nmrb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [nmrb_pkg::STATUS_W-1:0] status;
	logic [nmrb_pkg::MBX_W-1:0]    opened_index;
	logic [nmrb_pkg::DATA_W-1:0]   recv_data;
	logic [nmrb_pkg::FREEB_W-1:0]  free_bytes;

	modport source (output valid, status, opened_index, recv_data, free_bytes,
		input ready);
	modport sink (input valid, status, opened_index, recv_data, free_bytes,
		output ready);
endinterface
`default_nettype wire

[sv/nmrb_byte_ram.sv]
`default_nettype none
// Single-port RAM, registered read
module nmrb_byte_ram #(
	parameter int WORDS  = 1024,
	parameter int DATA_W = 8
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(WORDS)-1:0]  addr,
	input  wire logic [DATA_W-1:0]         wdata,
	output logic      [DATA_W-1:0]         rdata
);

	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

[sv/named_mailbox_ring_buffers_core.sv]
`default_nettype none
// Bank of named byte mailboxes behind one request/response pair. One request is
// worked on at a time; ready is high only while the block is idle and returns in
// the cycle after the result is taken. Open scans the searchable mailboxes one
// per cycle with a single 64-bit name compare and stops at the first name match;
// with no match it claims the first free mailbox that it saw, or reports that
// none is free. Send and receive move one byte per cycle through the single port
// of the byte RAM; a blocked or empty transfer moves no bytes. The result then
// waits in its register until taken. No clearing pass runs after reset: pointers
// and free counts reset at once and the byte RAM is read only where data was sent.
module named_mailbox_ring_buffers_core (
	input wire logic  clk,
	input wire logic  arst_n,
	nmrb_req_if.sink  req,
	nmrb_rsp_if.source rsp
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_EXEC     = 7'b0000010,
		ST_SCAN     = 7'b0000100,
		ST_OPEN_FIN = 7'b0001000,
		ST_COPY     = 7'b0010000,
		ST_FINISH   = 7'b0100000,
		ST_RESP     = 7'b1000000
	} state_t;

	state_t state_q;

	// Latched request
	nmrb_pkg::op_t                   op_q;
	logic [nmrb_pkg::IDX_W-1:0]      idx_q;
	logic [nmrb_pkg::KEY_W-1:0]      key_q;
	logic [nmrb_pkg::DATA_W-1:0]     data_q;
	logic [nmrb_pkg::CNT_W-1:0]      cnt_q;

	// Sequencer working registers
	logic [nmrb_pkg::SCAN_W-1:0]     scan_q;
	logic                            have_free_q;
	logic [nmrb_pkg::SCAN_W-1:0]     free_idx_q;
	logic [2:0]                      k_q;
	logic [nmrb_pkg::POS_W-1:0]      pos_q;
	logic                            rd_valid_q;
	logic [2:0]                      rd_lane_q;

	// Result registers
	nmrb_pkg::status_t               status_q;
	logic [nmrb_pkg::MBX_W-1:0]      opened_q;
	logic [nmrb_pkg::DATA_W-1:0]     rdata_q;
	logic [nmrb_pkg::FREE_W-1:0]     freeb_q;

	// Per-mailbox state
	logic                            in_use_q [nmrb_pkg::MAILBOXES];
	logic [nmrb_pkg::KEY_W-1:0]      name_q   [nmrb_pkg::MAILBOXES];
	logic [nmrb_pkg::POS_W-1:0]      rp_q     [nmrb_pkg::MAILBOXES];
	logic [nmrb_pkg::POS_W-1:0]      wp_q     [nmrb_pkg::MAILBOXES];
	logic [nmrb_pkg::FREE_W-1:0]     free_q   [nmrb_pkg::MAILBOXES];

	// Byte RAM port
	logic                            ram_we;
	logic [nmrb_pkg::ADDR_W-1:0]     ram_addr;
	logic [7:0]                      ram_wdata;
	logic [7:0]                      ram_rdata;

	logic                            req_take;
	logic [nmrb_pkg::CNT_W-1:0]      cnt_in;
	logic                            idx_ok_in;
	logic [nmrb_pkg::IDX_W-1:0]      box_sel;
	logic [nmrb_pkg::FREE_W-1:0]     box_free;
	logic [nmrb_pkg::FREE_W-1:0]     box_used;
	logic [nmrb_pkg::FREE_W-1:0]     cnt_f;
	logic                            scan_hit;
	logic                            scan_last;
	logic                            any_free;
	logic [nmrb_pkg::SCAN_W-1:0]     free_sel;
	logic                            claim_en;
	logic                            close_en;
	logic [nmrb_pkg::CNT_W-1:0]      cnt_m1;
	logic                            copy_last;
	logic [nmrb_pkg::POS_W-1:0]      pos_nx;
	logic [nmrb_pkg::FREE_W-1:0]     free_upd;
	logic                            commit_en;

	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;

	// Request decode
	assign cnt_in    = (req.byte_count > nmrb_pkg::CNT_W'(nmrb_pkg::MAX_BYTES))
		? nmrb_pkg::CNT_W'(nmrb_pkg::MAX_BYTES) : req.byte_count;
	assign idx_ok_in = 32'(req.mailbox_index) < 32'(nmrb_pkg::MAILBOXES);

	// One mailbox is looked at per cycle: scan index during search, else request index
	assign box_sel  = (state_q == ST_SCAN) ? nmrb_pkg::IDX_W'(scan_q) : idx_q;
	assign box_free = free_q[box_sel];
	assign box_used = nmrb_pkg::FREE_W'(nmrb_pkg::RING_BYTES) - box_free;
	assign cnt_f    = nmrb_pkg::FREE_W'(cnt_q);

	// Name search
	assign scan_hit  = in_use_q[box_sel] && (name_q[box_sel] == key_q);
	assign scan_last = (scan_q == nmrb_pkg::SCAN_W'(nmrb_pkg::OPEN_SPAN - 1));
	assign any_free  = have_free_q || !in_use_q[box_sel];
	assign free_sel  = have_free_q ? free_idx_q : scan_q;
	assign claim_en  = (state_q == ST_SCAN) && !scan_hit && scan_last && any_free;
	assign close_en  = (state_q == ST_EXEC) && (op_q == nmrb_pkg::OP_CLOSE);

	// Byte copy
	assign cnt_m1    = cnt_q - nmrb_pkg::CNT_W'(1);
	assign copy_last = ({1'b0, k_q} == cnt_m1);
	assign pos_nx    = nmrb_pkg::pos_next(pos_q);
	assign free_upd  = (op_q == nmrb_pkg::OP_SEND) ? (box_free - cnt_f) : (box_free + cnt_f);
	assign commit_en = (state_q == ST_COPY) && copy_last;

	assign ram_we    = (state_q == ST_COPY) && (op_q == nmrb_pkg::OP_SEND);
	assign ram_addr  = nmrb_pkg::ADDR_W'(idx_q) * nmrb_pkg::ADDR_W'(nmrb_pkg::RING_BYTES)
		+ nmrb_pkg::ADDR_W'(pos_q);
	assign ram_wdata = data_q[8*k_q +: 8];

	nmrb_byte_ram #(
		.WORDS  (nmrb_pkg::WORDS),
		.DATA_W (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_free_q <= 1'b0;
			rd_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						have_free_q <= 1'b0;
						if (nmrb_pkg::op_t'(req.op) == nmrb_pkg::OP_OPEN)
							state_q <= ST_SCAN;
						else if (idx_ok_in)
							state_q <= ST_EXEC;
						else
							state_q <= ST_RESP;
					end
				end
				ST_EXEC: begin
					if (op_q == nmrb_pkg::OP_CLOSE)
						state_q <= ST_RESP;
					else if (op_q == nmrb_pkg::OP_SEND && box_free < cnt_f)
						state_q <= ST_RESP;
					else if (op_q == nmrb_pkg::OP_RECV && box_used < cnt_f)
						state_q <= ST_RESP;
					else if (cnt_q == '0)
						state_q <= ST_RESP;
					else
						state_q <= ST_COPY;
				end
				ST_SCAN: begin
					if (!in_use_q[box_sel] && !have_free_q)
						have_free_q <= 1'b1;
					if (scan_hit)
						state_q <= ST_OPEN_FIN;
					else if (scan_last)
						state_q <= any_free ? ST_OPEN_FIN : ST_RESP;
				end
				ST_OPEN_FIN: begin
					state_q <= ST_RESP;
				end
				ST_COPY: begin
					rd_valid_q <= (op_q == nmrb_pkg::OP_RECV);
					if (copy_last)
						state_q <= (op_q == nmrb_pkg::OP_RECV) ? ST_FINISH : ST_RESP;
				end
				ST_FINISH: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp.ready)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					op_q     <= nmrb_pkg::op_t'(req.op);
					idx_q    <= nmrb_pkg::IDX_W'(req.mailbox_index);
					key_q    <= req.name_key;
					data_q   <= req.msg_data;
					cnt_q    <= cnt_in;
					scan_q   <= '0;
					k_q      <= '0;
					status_q <= nmrb_pkg::STS_OK;
					opened_q <= '0;
					rdata_q  <= '0;
					freeb_q  <= '0;
				end
			end
			ST_EXEC: begin
				pos_q <= (op_q == nmrb_pkg::OP_SEND) ? wp_q[idx_q] : rp_q[idx_q];
				if (op_q == nmrb_pkg::OP_CLOSE) begin
					freeb_q <= nmrb_pkg::FREE_W'(nmrb_pkg::RING_BYTES);
				end else begin
					freeb_q <= box_free;
					if ((op_q == nmrb_pkg::OP_SEND && box_free < cnt_f)
						|| (op_q == nmrb_pkg::OP_RECV && box_used < cnt_f))
						status_q <= nmrb_pkg::STS_BLOCK;
				end
			end
			ST_SCAN: begin
				scan_q <= scan_q + nmrb_pkg::SCAN_W'(1);
				if (!in_use_q[box_sel] && !have_free_q)
					free_idx_q <= scan_q;
				if (scan_hit) begin
					idx_q    <= box_sel;
					opened_q <= nmrb_pkg::MBX_W'(scan_q);
				end else if (scan_last) begin
					if (any_free) begin
						idx_q    <= nmrb_pkg::IDX_W'(free_sel);
						opened_q <= nmrb_pkg::MBX_W'(free_sel);
					end else begin
						status_q <= nmrb_pkg::STS_NOFREE;
					end
				end
			end
			ST_OPEN_FIN: begin
				freeb_q <= box_free;
			end
			ST_COPY: begin
				k_q       <= k_q + 3'd1;
				pos_q     <= pos_nx;
				rd_lane_q <= k_q;
				if (copy_last)
					freeb_q <= free_upd;
			end
			default: begin
			end
		endcase
		// Read data lands in the cycle after its address
		if (rd_valid_q)
			rdata_q[8*rd_lane_q +: 8] <= ram_rdata;
	end

	// Mailbox control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < nmrb_pkg::MAILBOXES; b++) begin
				in_use_q[b] <= 1'b0;
				rp_q[b]     <= '0;
				wp_q[b]     <= '0;
				free_q[b]   <= nmrb_pkg::FREE_W'(nmrb_pkg::RING_BYTES);
			end
		end else begin
			if (close_en) begin
				in_use_q[idx_q] <= 1'b0;
				rp_q[idx_q]     <= '0;
				wp_q[idx_q]     <= '0;
				free_q[idx_q]   <= nmrb_pkg::FREE_W'(nmrb_pkg::RING_BYTES);
			end
			if (claim_en)
				in_use_q[nmrb_pkg::IDX_W'(free_sel)] <= 1'b1;
			if (commit_en) begin
				if (op_q == nmrb_pkg::OP_SEND)
					wp_q[idx_q] <= pos_nx;
				else
					rp_q[idx_q] <= pos_nx;
				free_q[idx_q] <= free_upd;
			end
		end
	end

	// Names are written only when a mailbox is claimed
	always_ff @(posedge clk) begin
		if (claim_en)
			name_q[nmrb_pkg::IDX_W'(free_sel)] <= key_q;
	end

	// Response
	assign rsp.valid        = (state_q == ST_RESP);
	assign rsp.status       = status_q;
	assign rsp.opened_index = opened_q;
	assign rsp.recv_data    = rdata_q;
	assign rsp.free_bytes   = nmrb_pkg::FREEB_W'(freeb_q);

endmodule
`default_nettype wire
